@@ rtl/bsld_pkg.sv @@
// ----------------------------------------------------------------------------
// bsld_pkg - shared constants and types for the button click detector
// Sizes of the button bank, register widths and register indexes.
// ----------------------------------------------------------------------------
package bsld_pkg;

    // Size of the button bank and of the per-button hold counters.
    localparam int NUM_BUTTONS = 5;
    localparam int COUNT_WIDTH = 16;

    // Field widths of the ports.
    localparam int PIN_WIDTH   = 5;
    localparam int CODE_WIDTH  = 4;
    localparam int CFG_WIDTH   = 16;
    localparam int INDEX_WIDTH = 1;

    // Comparisons between a hold count and a register run at this width.
    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    // Reset values of the registers.
    localparam logic [CFG_WIDTH-1:0] MIN_COUNT_RESET      = CFG_WIDTH'(5);
    localparam logic [CFG_WIDTH-1:0] LONG_THRESHOLD_RESET = CFG_WIDTH'(75);

    // The hold counter saturates at its all-ones value.
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Event code meaning "no event" on this tick.
    localparam logic [CODE_WIDTH-1:0] EVENT_NONE = '0;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CODE_WIDTH-1:0]  code_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_data_t;

    // Register indexes of the configuration port.
    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_MIN_COUNT      = 1'b0,
        REG_LONG_THRESHOLD = 1'b1
    } reg_index_t;

endpackage

@@ rtl/button_short_long_click_detector_top.sv @@
// ----------------------------------------------------------------------------
// button_short_long_click_detector_top - short and long click detector
// Scans a bank of active-low buttons, one item per scan tick, and reports
// at most one short or long click per tick as an event code.
// An item's event code is registered on acceptance and shown in the next cycle.
// Throughput: one item per cycle while no result is stalled; the whole per-button
// update and the priority pick sit between the state registers and the output register.
// Reset: all buttons released, counters and long flags cleared, registers at
// their defaults (min_count 5, long_threshold 75), no result pending.
// ----------------------------------------------------------------------------
module button_short_long_click_detector_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Scan tick input channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bsld_pkg::PIN_WIDTH-1:0]        pin_levels,

    // Event output channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bsld_pkg::CODE_WIDTH-1:0]       event_code,

    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bsld_pkg::INDEX_WIDTH-1:0]      cfg_index,
    input  logic [bsld_pkg::CFG_WIDTH-1:0]        cfg_data
);

    localparam int NB = bsld_pkg::NUM_BUTTONS;

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------------
    bsld_pkg::cfg_data_t min_count_reg;
    bsld_pkg::cfg_data_t long_threshold_reg;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg      <= bsld_pkg::MIN_COUNT_RESET;
            long_threshold_reg <= bsld_pkg::LONG_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (bsld_pkg::reg_index_t'(cfg_index))
                bsld_pkg::REG_MIN_COUNT:
                begin
                    min_count_reg <= cfg_data;
                end
                bsld_pkg::REG_LONG_THRESHOLD:
                begin
                    long_threshold_reg <= cfg_data;
                end
                default:
                begin
                    min_count_reg <= min_count_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. A new item is taken whenever the output register is empty
    // or its item leaves in the same cycle, so ticks can arrive back to back.
    // ------------------------------------------------------------------------
    logic in_accept;
    logic out_valid_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------------
    // Per-button state.
    // ------------------------------------------------------------------------
    logic [NB-1:0]           pressed_now_reg;
    logic [NB-1:0]           pressed_before_reg;
    bsld_pkg::count_t        hold_count_reg [NB];
    logic [NB-1:0]           long_flag_reg;
    logic [NB-1:0]           long_flag_before_reg;

    // Candidate updates of each button, as if no earlier button had an event.
    logic [NB-1:0]           pressed_now_next;
    bsld_pkg::count_t        cand_count [NB];
    logic [NB-1:0]           cand_long;
    logic [NB-1:0]           cand_long_before;
    logic [NB-1:0]           short_click;
    logic [NB-1:0]           long_click;

    // Values written on an accepted tick after the priority pick.
    bsld_pkg::count_t        hold_count_next [NB];
    logic [NB-1:0]           long_flag_next;
    logic [NB-1:0]           long_flag_before_next;
    bsld_pkg::code_t         event_code_next;

    // A pin beyond the input field reads level 0, which means pressed.
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            if (i < bsld_pkg::PIN_WIDTH)
            begin
                pressed_now_next[i] = !pin_levels[i];
            end
            else
            begin
                pressed_now_next[i] = 1'b1;
            end
        end
    end

    // Each button's counter, long flag and click detection. The counter
    // counts while the button is held and has not saturated; the long flag
    // follows the new count. A release clears the counter and is a short
    // click if the press was not long and lasted at least min_count ticks.
    // A rising edge of the long flag is a long click, also while a release
    // of this button gave no short click.
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            cand_count[i]       = hold_count_reg[i];
            cand_long[i]        = long_flag_reg[i];
            cand_long_before[i] = long_flag_before_reg[i];
            short_click[i]      = 1'b0;

            if (pressed_now_next[i] && (hold_count_reg[i] != bsld_pkg::COUNT_MAX))
            begin
                cand_count[i]       = hold_count_reg[i] + bsld_pkg::count_t'(1);
                cand_long_before[i] = long_flag_reg[i];
                cand_long[i]        = bsld_pkg::CMP_WIDTH'(cand_count[i])
                                      > bsld_pkg::CMP_WIDTH'(long_threshold_reg);
            end

            if (!pressed_now_next[i] && pressed_now_reg[i])
            begin
                cand_count[i]  = '0;
                short_click[i] = !cand_long[i]
                                 && (bsld_pkg::CMP_WIDTH'(hold_count_reg[i])
                                     >= bsld_pkg::CMP_WIDTH'(min_count_reg));
            end

            long_click[i] = !short_click[i] && cand_long[i] && !cand_long_before[i];
        end
    end

    // Priority pick: the lowest button with an event is reported, and every
    // button after it keeps its counter and flags on this tick.
    always_comb
    begin
        logic blocked;
        blocked         = 1'b0;
        event_code_next = bsld_pkg::EVENT_NONE;
        for (int i = 0; i < NB; i++)
        begin
            hold_count_next[i]       = hold_count_reg[i];
            long_flag_next[i]        = long_flag_reg[i];
            long_flag_before_next[i] = long_flag_before_reg[i];
            if (!blocked)
            begin
                hold_count_next[i]       = cand_count[i];
                long_flag_next[i]        = cand_long[i];
                long_flag_before_next[i] = cand_long_before[i];
                if (short_click[i])
                begin
                    event_code_next = bsld_pkg::CODE_WIDTH'(2 * i + 1);
                    blocked         = 1'b1;
                end
                else if (long_click[i])
                begin
                    event_code_next = bsld_pkg::CODE_WIDTH'(2 * i + 2);
                    blocked         = 1'b1;
                end
            end
        end
    end

    // State update on every accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_now_reg      <= '0;
            pressed_before_reg   <= '0;
            long_flag_reg        <= '0;
            long_flag_before_reg <= '0;
            for (int i = 0; i < NB; i++)
            begin
                hold_count_reg[i] <= '0;
            end
        end
        else if (in_accept)
        begin
            pressed_now_reg      <= pressed_now_next;
            pressed_before_reg   <= pressed_now_reg;
            long_flag_reg        <= long_flag_next;
            long_flag_before_reg <= long_flag_before_next;
            for (int i = 0; i < NB; i++)
            begin
                hold_count_reg[i] <= hold_count_next[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register. It holds its item while the receiver stalls.
    // ------------------------------------------------------------------------
    bsld_pkg::code_t event_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            event_code_reg <= event_code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // Every accepted tick leaves an item in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
    else $error("accepted tick produced no result");

    // The input side only stalls while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
    else $error("input stalled with empty output register");

    // Button state never moves between accepted ticks.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(pressed_now_reg) && $stable(long_flag_reg)
                       && $stable(long_flag_before_reg))
    else $error("button state changed without an accepted tick");

    // Pressed history is a one-tick delay of the pressed bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pressed_before_reg == $past(pressed_now_reg))
    else $error("pressed history out of step");

    // A reported event code names an existing button.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(event_code_reg) <= 2 * NB))
    else $error("event code out of range");

endmodule
